// File: hw/rtl/block_line_index_seek_macros.svh
// ----------------------------------------------------------------------------
// Line index seek: assertion macros
// Clocked property helpers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_LINE_INDEX_SEEK_MACROS_SVH
`define BLOCK_LINE_INDEX_SEEK_MACROS_SVH

// Property that must hold at every edge outside reset
`define BLIS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("line index seek check failed");

// Antecedent in this cycle implies consequent in the next cycle
`define BLIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("line index seek sequence check failed");

`endif

// File: hw/rtl/blis_pkg.sv
// ----------------------------------------------------------------------------
// Line index seek package
// Sizes, codes, transaction types and a saturating helper.
// ----------------------------------------------------------------------------
package blis_pkg;

  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LC_W       = 48;
  localparam int unsigned OFF_W      = 32;

  localparam logic [7:0]       NEWLINE     = 8'h0A;
  localparam logic [LC_W-1:0]  LC_MAX      = '1;
  localparam logic [OFF_W-1:0] OFF_MAX     = '1;
  localparam logic [CNT_W-1:0] BLOCKS_FULL = CNT_W'(MAX_BLOCKS);

  // Request codes; code 3 is ignored
  typedef enum logic [1:0] {
    REQ_DATA = 2'd0,
    REQ_END  = 2'd1,
    REQ_SEEK = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_SUMMARY  = 2'd0,
    KIND_FOUND    = 2'd1,
    KIND_PAST_END = 2'd2,
    KIND_FULL     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [7:0]      data_byte;
    logic [LC_W-1:0] target_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [IDX_W-1:0] block_index;
    logic [LC_W-1:0]  start_line;
    logic [OFF_W-1:0] line_offset;
    logic [LC_W-1:0]  line_total;
    logic [LC_W-1:0]  skip_lines;
  } out_item_t;

  // Per-block statistics
  typedef struct packed {
    logic [OFF_W-1:0] byte_count;
    logic [OFF_W-1:0] newline_count;
    logic [OFF_W-1:0] first_nl_pos;
    logic             first_nl_seen;
    logic             last_nl;
  } acc_t;

  // Control into the search sequencer
  typedef struct packed {
    logic             start;
    logic             take;
    logic [CNT_W-1:0] count;
    logic [LC_W-1:0]  target;
  } srch_ctl_t;

  // Status out of the search sequencer
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] best;
    logic [LC_W-1:0]  start_line;
    logic [OFF_W-1:0] line_offset;
    logic [LC_W-1:0]  skip;
  } srch_stat_t;

  function automatic logic [LC_W-1:0] sat_inc_lc(input logic [LC_W-1:0] a);
    sat_inc_lc = (a == LC_MAX) ? a : a + 1'b1;
  endfunction

endpackage

// File: hw/rtl/blis_accum.sv
// ----------------------------------------------------------------------------
// Line index seek: block statistics
// Counts bytes and newlines of the open block, notes the first newline and whether the last byte was one.
// ----------------------------------------------------------------------------
module blis_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_valid_i,
  input  logic [7:0]     byte_i,
  input  logic           clear_i,
  output blis_pkg::acc_t acc_o
);

  blis_pkg::acc_t acc_d, acc_q;

  // Next-state of the counters
  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (byte_valid_i) begin
      if (byte_i == blis_pkg::NEWLINE) begin
        if (!acc_q.first_nl_seen) begin
          acc_d.first_nl_seen = 1'b1;
          acc_d.first_nl_pos  = acc_q.byte_count;
        end
        if (acc_q.newline_count != blis_pkg::OFF_MAX) begin
          acc_d.newline_count = acc_q.newline_count + 1'b1;
        end
        acc_d.last_nl = 1'b1;
      end else begin
        acc_d.last_nl = 1'b0;
      end
      if (acc_q.byte_count != blis_pkg::OFF_MAX) begin
        acc_d.byte_count = acc_q.byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: hw/rtl/blis_table.sv
// ----------------------------------------------------------------------------
// Line index seek: block table
// First line and line offset per block, one write and one registered read.
// ----------------------------------------------------------------------------
module blis_table (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [blis_pkg::IDX_W-1:0]    waddr_i,
  input  logic [blis_pkg::LC_W-1:0]     wfl_i,
  input  logic [blis_pkg::OFF_W-1:0]    woff_i,
  input  logic                          re_i,
  input  logic [blis_pkg::IDX_W-1:0]    raddr_i,
  output logic [blis_pkg::LC_W-1:0]     rfl_o,
  output logic [blis_pkg::OFF_W-1:0]    roff_o
);

  logic [blis_pkg::LC_W-1:0]  fl_mem  [blis_pkg::MAX_BLOCKS];
  logic [blis_pkg::OFF_W-1:0] off_mem [blis_pkg::MAX_BLOCKS];
  logic [blis_pkg::LC_W-1:0]  rfl_q;
  logic [blis_pkg::OFF_W-1:0] roff_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      fl_mem[waddr_i]  <= wfl_i;
      off_mem[waddr_i] <= woff_i;
    end
  end

  // Registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rfl_q  <= fl_mem[raddr_i];
      roff_q <= off_mem[raddr_i];
    end
  end

  assign rfl_o  = rfl_q;
  assign roff_o = roff_q;

endmodule

// File: hw/rtl/blis_search.sv
// ----------------------------------------------------------------------------
// Line index seek: binary search sequencer
// Finds the last stored block whose first line is at or below the target,
// one table read and one compare per step.
// ----------------------------------------------------------------------------
module blis_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  blis_pkg::srch_ctl_t           ctl_i,
  output logic                          re_o,
  output logic [blis_pkg::IDX_W-1:0]    raddr_o,
  input  logic [blis_pkg::LC_W-1:0]     rfl_i,
  input  logic [blis_pkg::OFF_W-1:0]    roff_i,
  output blis_pkg::srch_stat_t          stat_o
);

  typedef enum logic [3:0] {
    SR_IDLE = 4'b0001,
    SR_STEP = 4'b0010,
    SR_CMP  = 4'b0100,
    SR_DONE = 4'b1000
  } sr_state_e;

  sr_state_e                     state_d, state_q;
  logic [blis_pkg::CNT_W-1:0]    lo_d, lo_q, hi_d, hi_q, mid;
  logic [blis_pkg::IDX_W-1:0]    best_d, best_q;
  logic [blis_pkg::LC_W-1:0]     target_d, target_q;
  logic                          open;

  assign open = lo_q < hi_q;
  assign mid  = lo_q + ((hi_q - lo_q) >> 1);

  // Read the midpoint while the range is open, the winner once it closes
  assign re_o    = (state_q == SR_STEP);
  assign raddr_o = open ? mid[blis_pkg::IDX_W-1:0] : best_q;

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    best_d   = best_q;
    target_d = target_q;
    case (state_q)
      SR_IDLE: begin
        if (ctl_i.start) begin
          lo_d     = '0;
          hi_d     = ctl_i.count;
          best_d   = '0;
          target_d = ctl_i.target;
          state_d  = SR_STEP;
        end
      end
      SR_STEP: begin
        state_d = open ? SR_CMP : SR_DONE;
      end
      SR_CMP: begin
        // shared compare against the entry just read
        if (rfl_i <= target_q) begin
          best_d = mid[blis_pkg::IDX_W-1:0];
          lo_d   = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
        state_d = SR_STEP;
      end
      SR_DONE: begin
        if (ctl_i.take) begin
          state_d = SR_IDLE;
        end
      end
      default: state_d = SR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
  end

  // Result, valid in the done state
  always_comb begin
    stat_o             = '0;
    stat_o.done        = (state_q == SR_DONE);
    stat_o.best        = best_q;
    stat_o.start_line  = rfl_i;
    stat_o.line_offset = roff_i;
    stat_o.skip        = target_q - rfl_i;
  end

endmodule

// File: hw/rtl/block_line_index_seek.sv
// ----------------------------------------------------------------------------
// Line index with binary search seek
// Data bytes and ignored requests: one per cycle while not stalled, no result.
// Block end: table write, then total and summary; with a full table, a full result.
// Seek: past end answers in the cycle after acceptance; found runs S search
// steps (at most ceil(log2(blocks+1))), a table read and a compare each.
// Reset clears counters, line total and sequencers; tables are not cleared.
// ----------------------------------------------------------------------------
module block_line_index_seek (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  blis_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output blis_pkg::out_item_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLOSE = 3'b010,
    ST_SEEK  = 3'b100
  } state_e;

  state_e                        state_d, state_q;
  logic [blis_pkg::LC_W-1:0]     prefix_d, prefix_q;
  logic [blis_pkg::LC_W-1:0]     total_d, total_q;
  logic [blis_pkg::CNT_W-1:0]    blocks_d, blocks_q;
  logic                          prev_nl_d, prev_nl_q;
  logic [blis_pkg::IDX_W-1:0]    cl_idx_d, cl_idx_q;
  logic [blis_pkg::LC_W-1:0]     cl_fl_d, cl_fl_q;
  logic [blis_pkg::OFF_W-1:0]    cl_off_d, cl_off_q;
  logic                          out_valid_d, out_valid_q;
  blis_pkg::out_item_t           out_d, out_q;

  blis_pkg::acc_t                acc;
  blis_pkg::srch_ctl_t           sctl;
  blis_pkg::srch_stat_t          sstat;
  logic                          accept, is_data, is_end, is_seek, out_free, full;
  logic                          we, re;
  logic [blis_pkg::IDX_W-1:0]    raddr;
  logic [blis_pkg::LC_W-1:0]     rfl;
  logic [blis_pkg::OFF_W-1:0]    roff;
  logic [blis_pkg::LC_W:0]       prefix_sum;
  logic [blis_pkg::LC_W-1:0]     prefix_sat, fl_new, total_new;
  logic [blis_pkg::OFF_W-1:0]    off_new;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_data    = accept && (in_data_i.req_type == blis_pkg::REQ_DATA);
  assign is_end     = accept && (in_data_i.req_type == blis_pkg::REQ_END);
  assign is_seek    = accept && (in_data_i.req_type == blis_pkg::REQ_SEEK);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (blocks_q == blis_pkg::BLOCKS_FULL);

  blis_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (is_data),
    .byte_i       (in_data_i.data_byte),
    .clear_i      (is_end),
    .acc_o        (acc)
  );

  blis_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (blocks_q[blis_pkg::IDX_W-1:0]),
    .wfl_i   (fl_new),
    .woff_i  (off_new),
    .re_i    (re),
    .raddr_i (raddr),
    .rfl_o   (rfl),
    .roff_o  (roff)
  );

  blis_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sctl),
    .re_o    (re),
    .raddr_o (raddr),
    .rfl_i   (rfl),
    .roff_i  (roff),
    .stat_o  (sstat)
  );

  // Saturating prefix update with this block's newlines
  assign prefix_sum = {1'b0, prefix_q} + (blis_pkg::LC_W + 1)'(acc.newline_count);
  assign prefix_sat = prefix_sum[blis_pkg::LC_W] ? blis_pkg::LC_MAX
                                                 : prefix_sum[blis_pkg::LC_W-1:0];

  // Where the closing block's first own line starts
  always_comb begin
    if (blocks_q == '0) begin
      fl_new  = '0;
      off_new = '0;
    end else if (prev_nl_q) begin
      fl_new  = prefix_q;
      off_new = '0;
    end else begin
      fl_new = blis_pkg::sat_inc_lc(prefix_q);
      if (acc.first_nl_seen) begin
        off_new = (acc.first_nl_pos == blis_pkg::OFF_MAX) ? blis_pkg::OFF_MAX
                                                         : acc.first_nl_pos + 1'b1;
      end else begin
        off_new = acc.byte_count;
      end
    end
  end

  // Running total from the already updated prefix
  assign total_new = prev_nl_q ? prefix_q : blis_pkg::sat_inc_lc(prefix_q);

  // Control sequencer
  always_comb begin
    state_d     = state_q;
    prefix_d    = prefix_q;
    total_d     = total_q;
    blocks_d    = blocks_q;
    prev_nl_d   = prev_nl_q;
    cl_idx_d    = cl_idx_q;
    cl_fl_d     = cl_fl_q;
    cl_off_d    = cl_off_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    sctl        = '0;
    sctl.count  = blocks_q;
    sctl.target = in_data_i.target_line;
    case (state_q)
      ST_IDLE: begin
        if (is_end) begin
          if (full) begin
            out_valid_d      = 1'b1;
            out_d            = '0;
            out_d.result_kind = blis_pkg::KIND_FULL;
            out_d.line_total = total_q;
          end else begin
            we        = 1'b1;
            prefix_d  = prefix_sat;
            prev_nl_d = acc.last_nl;
            blocks_d  = blocks_q + 1'b1;
            cl_idx_d  = blocks_q[blis_pkg::IDX_W-1:0];
            cl_fl_d   = fl_new;
            cl_off_d  = off_new;
            state_d   = ST_CLOSE;
          end
        end else if (is_seek) begin
          if ((blocks_q == '0) || (in_data_i.target_line >= total_q)) begin
            out_valid_d       = 1'b1;
            out_d             = '0;
            out_d.result_kind = blis_pkg::KIND_PAST_END;
            out_d.line_total  = total_q;
          end else begin
            sctl.start = 1'b1;
            state_d    = ST_SEEK;
          end
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          total_d           = total_new;
          out_valid_d       = 1'b1;
          out_d.result_kind = blis_pkg::KIND_SUMMARY;
          out_d.block_index = cl_idx_q;
          out_d.start_line  = cl_fl_q;
          out_d.line_offset = cl_off_q;
          out_d.line_total  = total_new;
          out_d.skip_lines  = '0;
          state_d           = ST_IDLE;
        end
      end
      ST_SEEK: begin
        if (sstat.done && out_free) begin
          sctl.take         = 1'b1;
          out_valid_d       = 1'b1;
          out_d.result_kind = blis_pkg::KIND_FOUND;
          out_d.block_index = sstat.best;
          out_d.start_line  = sstat.start_line;
          out_d.line_offset = sstat.line_offset;
          out_d.line_total  = total_q;
          out_d.skip_lines  = sstat.skip;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prefix_q    <= '0;
      total_q     <= '0;
      blocks_q    <= '0;
      prev_nl_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      total_q     <= total_d;
      blocks_q    <= blocks_d;
      prev_nl_q   <= prev_nl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cl_idx_q <= cl_idx_d;
    cl_fl_q  <= cl_fl_d;
    cl_off_q <= cl_off_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/blis_checker.sv
// ----------------------------------------------------------------------------
// Line index seek: port checker
// Checks result transactions and seek handling seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "block_line_index_seek_macros.svh"

module blis_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input blis_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input blis_pkg::out_item_t out_data_o
);

  // A stalled result holds
  `BLIS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o))

  // An accepted seek either answers next cycle or keeps the input stalled
  `BLIS_ASSERT_NEXT(a_seek_resp, clk_i, rst_ni,
                    in_valid_i && !in_stall_o &&
                    (in_data_i.req_type == blis_pkg::REQ_SEEK),
                    out_valid_o || in_stall_o)

  // Rejected seeks and dropped blocks carry only the line total
  `BLIS_ASSERT(a_reject_zero, clk_i, rst_ni,
               !(out_valid_o &&
                 ((out_data_o.result_kind == blis_pkg::KIND_PAST_END) ||
                  (out_data_o.result_kind == blis_pkg::KIND_FULL))) ||
               ((out_data_o.block_index == '0) && (out_data_o.start_line == '0) &&
                (out_data_o.line_offset == '0) && (out_data_o.skip_lines == '0)))

  // A found line lies inside the counted lines
  `BLIS_ASSERT(a_found_range, clk_i, rst_ni,
               !(out_valid_o && (out_data_o.result_kind == blis_pkg::KIND_FOUND)) ||
               (out_data_o.skip_lines < out_data_o.line_total))

endmodule

bind block_line_index_seek blis_checker u_blis_checker (.*);
